### rtl/core/stpn_pkg.sv
// Package for the top-k peak picker with base-peak normalization.
// Holds payload structs, cell control struct, FSM states and register indexes.
// No dependencies.
`default_nettype none

package stpn_pkg;

  localparam int TOP_PEAKS_DEF = 64;
  localparam int DATA_W        = 32;
  localparam int CFG_IDX_W     = 1;

  localparam logic [DATA_W-1:0] BASE_INT_RST = DATA_W'(100000);
  localparam logic [DATA_W-1:0] MIN_INT_RST  = '0;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_INT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INT  = CFG_IDX_W'(1);

  typedef struct packed {
    logic [DATA_W-1:0] peak_mz;
    logic [DATA_W-1:0] peak_intensity;
    logic              last_in_spectrum;
  } peak_in_t;

  typedef struct packed {
    logic [DATA_W-1:0] out_mz;
    logic [DATA_W-1:0] out_intensity;
    logic              out_last;
  } peak_out_t;

  // Contents of one cell of the ordered store
  typedef struct packed {
    logic [DATA_W-1:0] mz;
    logic [DATA_W-1:0] intensity;
  } kept_t;

  // Commands broadcast to every cell
  typedef struct packed {
    logic ins;    // insert the broadcast peak
    logic full;   // store full: evict weakest while inserting
    logic shift;  // move every entry one cell toward cell 0
  } cell_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_EMIT,
    S_TOP
  } state_t;

endpackage

`default_nettype wire

### rtl/core/stpn_cell.sv
// One cell of the ordered peak store (ascending intensity toward higher cells).
// Depends on stpn_pkg for kept_t and cell_ctl_t.
`default_nettype none

module stpn_cell
  import stpn_pkg::*;
(
  input  wire logic              clk,
  input  wire cell_ctl_t         ctl,
  input  wire logic              occ,        // cell holds a kept peak
  input  wire kept_t             new_peak,
  input  wire logic              ge_below,   // lower neighbor stays below new peak
  input  wire kept_t             data_below,
  input  wire logic              ge_above,
  input  wire kept_t             data_above,
  output logic                   ge,
  output kept_t                  data
);

  kept_t data_r;
  kept_t data_nxt;

  // Entry ranks at or below the new peak (later arrival wins ties)
  assign ge   = occ && (data_r.intensity <= new_peak.intensity);
  assign data = data_r;

  // Select hold, load, or take from a neighbor
  always_comb begin
    data_nxt = data_r;
    if (ctl.shift) begin
      data_nxt = data_above;
    end else if (ctl.ins) begin
      if (ctl.full) begin
        if (ge && ge_above) begin
          data_nxt = data_above;
        end else if (ge) begin
          data_nxt = new_peak;
        end
      end else begin
        if (!ge) begin
          data_nxt = ge_below ? new_peak : data_below;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

`default_nettype wire

### rtl/core/stpn_scale.sv
// Scaling unit: floor(a * b / d), a registered multiply then a bit-serial divider.
// Gives 0 for d == 0. Depends on stpn_pkg for DATA_W.
`default_nettype none

module stpn_scale
  import stpn_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              go,
  input  wire logic [DATA_W-1:0] a,
  input  wire logic [DATA_W-1:0] b,
  input  wire logic [DATA_W-1:0] d,
  output logic                   done,
  output logic [DATA_W-1:0]      quo
);

  localparam int CNT_W = $clog2(DATA_W);

  logic [2*DATA_W-1:0] prod_r;
  logic [DATA_W-1:0]   d_r;
  logic [DATA_W-1:0]   rem_r, rem_nxt;
  logic [DATA_W-1:0]   q_r, q_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                ld_r, ld_nxt;
  logic                run_r, run_nxt;
  logic                done_r, done_nxt;
  logic [DATA_W:0]     trial;
  logic                fits;

  // One restoring step: bring down the next dividend bit
  assign trial = {rem_r, q_r[DATA_W-1]};
  assign fits  = (trial >= {1'b0, d_r});

  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    ld_nxt   = 1'b0;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (go) begin
      ld_nxt  = 1'b1;
      cnt_nxt = '0;
    end else if (ld_r) begin
      // High half is below d, so the quotient fits the low half
      rem_nxt = prod_r[2*DATA_W-1:DATA_W];
      q_nxt   = prod_r[DATA_W-1:0];
      run_nxt = 1'b1;
    end else if (run_r) begin
      rem_nxt = fits ? DATA_W'(trial - {1'b0, d_r}) : trial[DATA_W-1:0];
      q_nxt   = {q_r[DATA_W-2:0], fits};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DATA_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld_r   <= 1'b0;
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      ld_r   <= ld_nxt;
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (go) begin
      prod_r <= a * b;
      d_r    <= d;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quo  = (d_r == '0) ? '0 : q_r;

endmodule

`default_nettype wire

### rtl/core/spectrum_top_peak_normalizer.sv
// Top-k peak picker with base-peak normalization: chain of store cells,
// scaling unit and emission sequencer. Depends on stpn_pkg, stpn_cell, stpn_scale.
//
//  channel   ports                               handshake
//  input     start, busy, in_item                taken when start && !busy
//  result    out_valid, out_item                 one-cycle strobe, no stall
//  config    cfg_we, cfg_index, cfg_data         written when cfg_we
//
// A peak without the last mark keeps the block idle; cells insert it in place.
// After the last peak, each kept peak below the strongest is scaled by the
// bit-serial divider (one quotient bit per cycle); the strongest is emitted
// at the base level without division. busy stays high over that whole emission.
// Reset clears the fill count, configuration and sequencer; cell contents
// are not reset. The receiver cannot stall: each result shows for one cycle.
`default_nettype none

module spectrum_top_peak_normalizer
  import stpn_pkg::*;
#(
  parameter int TOP_PEAKS = TOP_PEAKS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire peak_in_t             in_item,
  output logic                      out_valid,
  output peak_out_t                 out_item,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DATA_W-1:0]    cfg_data
);

  localparam int CNT_W = $clog2(TOP_PEAKS + 1);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [DATA_W-1:0] max_r, max_nxt;
  logic [DATA_W-1:0] base_r, min_r;
  logic              out_valid_r, out_valid_nxt;
  peak_out_t         out_r, out_nxt;

  logic              accept;
  logic              full;
  logic              ins_en;
  logic              shift_en;
  logic              scale_go;
  logic              emit_mid;
  logic              emit_top;
  cell_ctl_t         ctl;
  kept_t             new_peak;
  logic              ge_w   [TOP_PEAKS];
  kept_t             data_w [TOP_PEAKS];
  logic              scale_done;
  logic [DATA_W-1:0] scale_quo;

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign full     = (count_r == CNT_W'(TOP_PEAKS));
  assign new_peak = '{mz: in_item.peak_mz, intensity: in_item.peak_intensity};

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept && in_item.last_in_spectrum) state_nxt = S_MUL;
      S_MUL:  state_nxt = (count_r == CNT_W'(1)) ? S_TOP : S_DIV;
      S_DIV:  if (scale_done) state_nxt = S_EMIT;
      S_EMIT: state_nxt = S_MUL;
      S_TOP:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control outputs per state
  always_comb begin
    ins_en   = 1'b0;
    shift_en = 1'b0;
    scale_go = 1'b0;
    emit_mid = 1'b0;
    emit_top = 1'b0;
    case (state_r)
      S_IDLE: ins_en   = accept && !(full && !ge_w[0]);
      S_MUL:  scale_go = (count_r != CNT_W'(1));
      S_EMIT: begin
        shift_en = 1'b1;
        emit_mid = (scale_quo >= min_r);
      end
      S_TOP:  emit_top = 1'b1;
      default: ;
    endcase
  end

  assign ctl = '{ins: ins_en, full: full, shift: shift_en};

  // Fill count and running maximum
  always_comb begin
    count_nxt = count_r;
    max_nxt   = max_r;
    if (ins_en) begin
      if (!full) count_nxt = count_r + CNT_W'(1);
      if ((count_r == '0) || (in_item.peak_intensity > max_r)) begin
        max_nxt = in_item.peak_intensity;
      end
    end else if (shift_en) begin
      count_nxt = count_r - CNT_W'(1);
    end else if (emit_top) begin
      count_nxt = '0;
    end
  end

  // Result register
  always_comb begin
    out_valid_nxt = emit_mid || emit_top;
    out_nxt       = out_r;
    if (emit_mid) begin
      out_nxt = '{out_mz: data_w[0].mz, out_intensity: scale_quo, out_last: 1'b0};
    end else if (emit_top) begin
      out_nxt = '{out_mz: data_w[0].mz, out_intensity: base_r, out_last: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      base_r      <= BASE_INT_RST;
      min_r       <= MIN_INT_RST;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_BASE_INT: base_r <= cfg_data;
          CFG_MIN_INT:  min_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    max_r <= max_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // Chain of store cells, cell 0 holds the weakest peak
  genvar gi;
  generate
    for (gi = 0; gi < TOP_PEAKS; gi++) begin : g_cell
      logic  ge_below, ge_above;
      kept_t data_below, data_above;
      if (gi == 0) begin : g_bot
        assign ge_below   = 1'b1;
        assign data_below = '0;
      end else begin : g_mid_lo
        assign ge_below   = ge_w[gi-1];
        assign data_below = data_w[gi-1];
      end
      if (gi == TOP_PEAKS - 1) begin : g_top
        assign ge_above   = 1'b0;
        assign data_above = '0;
      end else begin : g_mid_hi
        assign ge_above   = ge_w[gi+1];
        assign data_above = data_w[gi+1];
      end
      stpn_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .occ        (count_r > CNT_W'(gi)),
        .new_peak   (new_peak),
        .ge_below   (ge_below),
        .data_below (data_below),
        .ge_above   (ge_above),
        .data_above (data_above),
        .ge         (ge_w[gi]),
        .data       (data_w[gi])
      );
    end
  endgenerate

  // Scale the weakest remaining peak against the maximum
  stpn_scale u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (scale_go),
    .a     (data_w[0].intensity),
    .b     (base_r),
    .d     (max_r),
    .done  (scale_done),
    .quo   (scale_quo)
  );

  // Store empties with the strongest peak's result
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.out_last |-> count_r == '0)
    else $error("store not cleared after final result");

  // Fill count never exceeds the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TOP_PEAKS))
    else $error("fill count beyond store depth");

  // A scaled result follows a completed division
  a_emit_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> $past(state_r) == S_DIV && $past(scale_done))
    else $error("emission without finished division");

  // No item taken while emission runs
  a_no_insert_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> $stable(count_r) || $past(state_r) == S_EMIT || $past(state_r) == S_TOP)
    else $error("store changed outside emission");

endmodule

`default_nettype wire

### sim/spectrum_top_peak_normalizer_test.sv
// Testbench for spectrum_top_peak_normalizer: streams peak spectra, predicts the
// normalized top-peak list of each spectrum and checks every emitted peak.
// Depends on stpn_pkg and the spectrum_top_peak_normalizer RTL.
`timescale 1ns / 1ps

module spectrum_top_peak_normalizer_test;
  import stpn_pkg::*;

  localparam int STORE_DEPTH  = TOP_PEAKS_DEF;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES  = 48;
  localparam int PRINT_LIMIT  = 40;

  // How the intensities of one generated spectrum are drawn
  typedef enum int {
    SPREAD_FULL,
    SPREAD_NARROW,
    SPREAD_ZERO,
    SPREAD_HIGH,
    SPREAD_CROWDED,
    SPREAD_MIXED
  } spread_t;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 start     = 1'b0;
  logic                 busy;
  peak_in_t             in_item   = '0;
  logic                 out_valid;
  peak_out_t            out_item;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_BASE_INT;
  logic [DATA_W-1:0]    cfg_data  = '0;

  // Predictor state: configuration and the ordered store of kept peaks
  logic [DATA_W-1:0] base_level  = BASE_INT_RST;
  logic [DATA_W-1:0] floor_level = MIN_INT_RST;
  logic [DATA_W-1:0] rank_int [STORE_DEPTH];
  logic [DATA_W-1:0] rank_mz  [STORE_DEPTH];
  int                rank_count = 0;
  peak_out_t         expected_peaks [$];

  int mismatch_count = 0;
  int peaks_sent     = 0;
  int spectra_sent   = 0;
  int peaks_checked  = 0;
  int burst_left     = 0;

  spectrum_top_peak_normalizer DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #40_000_000;
    $display("Timed out waiting for the block");
    $display("Some tests failed");
    $finish;
  end

  function automatic peak_in_t make_peak(input logic [DATA_W-1:0] mz,
                                         input logic [DATA_W-1:0] inten,
                                         input logic              is_end);
    peak_in_t p;
    p.peak_mz          = mz;
    p.peak_intensity   = inten;
    p.last_in_spectrum = is_end;
    return p;
  endfunction

  // Insert one peak into the ordered store; on the closing peak, queue the
  // normalized peaks in ascending order and empty the store.
  function automatic void rank_peak(input peak_in_t p);
    bit          kept;
    int          pos;
    int          top;
    logic [63:0] quot;
    peak_out_t   res;
    kept = 1'b1;
    if (rank_count >= STORE_DEPTH) begin
      if (p.peak_intensity < rank_int[0]) begin
        kept = 1'b0;
      end else begin
        for (int i = 1; i < rank_count; i++) begin
          rank_int[i-1] = rank_int[i];
          rank_mz[i-1]  = rank_mz[i];
        end
        rank_count--;
      end
    end
    if (kept) begin
      // later arrivals go above equal intensities
      pos = 0;
      while (pos < rank_count && rank_int[pos] <= p.peak_intensity) pos++;
      for (int i = rank_count; i > pos; i--) begin
        rank_int[i] = rank_int[i-1];
        rank_mz[i]  = rank_mz[i-1];
      end
      rank_int[pos] = p.peak_intensity;
      rank_mz[pos]  = p.peak_mz;
      rank_count++;
    end
    if (p.last_in_spectrum) begin
      top = rank_count - 1;
      for (int i = 0; i < top; i++) begin
        if (rank_int[top] == '0) begin
          quot = '0;
        end else begin
          quot = ({32'b0, rank_int[i]} * {32'b0, base_level}) / {32'b0, rank_int[top]};
        end
        if (quot[DATA_W-1:0] >= floor_level) begin
          res.out_mz        = rank_mz[i];
          res.out_intensity = quot[DATA_W-1:0];
          res.out_last      = 1'b0;
          expected_peaks.push_back(res);
        end
      end
      res.out_mz        = rank_mz[top];
      res.out_intensity = base_level;
      res.out_last      = 1'b1;
      expected_peaks.push_back(res);
      rank_count = 0;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) $display("%0t ns MISMATCH: %s", $time, msg);
  endtask

  // Compare each emitted peak with the oldest expected one
  always @(posedge clk) begin
    peak_out_t want;
    if (rst_n && out_valid) begin
      peaks_checked++;
      if (expected_peaks.size() == 0) begin
        report_mismatch($sformatf("unexpected peak mz=%h int=%h end=%b",
                                  out_item.out_mz, out_item.out_intensity,
                                  out_item.out_last));
      end else begin
        want = expected_peaks.pop_front();
        if (out_item.out_mz !== want.out_mz ||
            out_item.out_intensity !== want.out_intensity ||
            out_item.out_last !== want.out_last) begin
          report_mismatch($sformatf("got mz=%h int=%h end=%b, want mz=%h int=%h end=%b",
                                    out_item.out_mz, out_item.out_intensity,
                                    out_item.out_last, want.out_mz,
                                    want.out_intensity, want.out_last));
        end
      end
    end
  end

  // Offer one item, in bursts with random gaps, and hold it until taken
  task automatic send_peak(input peak_in_t p);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    start   <= 1'b1;
    in_item <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    rank_peak(p);
    peaks_sent++;
    if (p.last_in_spectrum) spectra_sent++;
  endtask

  // Drop start and wait until every expected peak is out and the block is idle
  task automatic settle_idle();
    start <= 1'b0;
    @(posedge clk);
    while (expected_peaks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Write both registers on consecutive cycles
  task automatic set_config(input logic [DATA_W-1:0] base, input logic [DATA_W-1:0] floor_val);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BASE_INT;
    cfg_data  <= base;
    @(posedge clk);
    cfg_index <= CFG_MIN_INT;
    cfg_data  <= floor_val;
    @(posedge clk);
    cfg_we      <= 1'b0;
    base_level  = base;
    floor_level = floor_val;
  endtask

  task automatic send_spectrum(input int len, input spread_t spread);
    logic [DATA_W-1:0] inten;
    spread_t           pick;
    for (int k = 0; k < len; k++) begin
      pick = (spread == SPREAD_MIXED) ? spread_t'($urandom_range(0, 4)) : spread;
      case (pick)
        SPREAD_NARROW:  inten = $urandom_range(0, 15);
        SPREAD_ZERO:    inten = '0;
        SPREAD_HIGH:    inten = 32'hFFFF_FFFF - $urandom_range(0, 7);
        SPREAD_CROWDED: inten = $urandom_range(0, 40);
        default:        inten = $urandom;
      endcase
      send_peak(make_peak($urandom, inten, k == len - 1));
    end
  endtask

  function automatic logic [DATA_W-1:0] pick_base();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom_range(1, 1000);
      3:       return BASE_INT_RST;
      default: return $urandom;
    endcase
  endfunction

  task automatic reset_block();
    rst_n <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
  endtask

  // Reset levels: lone zero peak, then field extremes
  task automatic test_reset_levels();
    send_peak(make_peak('0, '0, 1'b1));
    send_peak(make_peak(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
    send_peak(make_peak(32'h1234_5678, 32'h1, 1'b0));
    send_peak(make_peak('0, '0, 1'b0));
    send_peak(make_peak(32'hAAAA_5555, 32'h7FFF_FFFF, 1'b1));
    settle_idle();
  endtask

  // Equal intensities keep arrival order; an all-zero store scales to zero
  task automatic test_ties();
    set_config(32'd1000, '0);
    send_peak(make_peak(32'd1, 32'd500, 1'b0));
    send_peak(make_peak(32'd2, 32'd500, 1'b0));
    send_peak(make_peak(32'd3, 32'd500, 1'b0));
    send_peak(make_peak(32'd4, 32'd500, 1'b1));
    send_peak(make_peak(32'h5555_AAAA, '0, 1'b0));
    send_peak(make_peak(32'h0F0F_F0F0, '0, 1'b0));
    send_peak(make_peak(32'hF0F0_0F0F, '0, 1'b1));
    settle_idle();
  endtask

  // Threshold cases: strongest below threshold, all-ones levels, wide products
  task automatic test_thresholds();
    set_config('0, 32'd1);
    send_peak(make_peak(32'h100, 32'd3, 1'b0));
    send_peak(make_peak(32'h101, 32'd9, 1'b0));
    send_peak(make_peak(32'h102, 32'd6, 1'b1));
    settle_idle();
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_peak(make_peak(32'h200, 32'd5, 1'b0));
    send_peak(make_peak(32'h201, 32'd30, 1'b0));
    send_peak(make_peak(32'h202, 32'd30, 1'b1));
    settle_idle();
    set_config(32'hFFFF_FFFF, '0);
    send_peak(make_peak(32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0));
    send_peak(make_peak(32'h8000_0001, 32'd1, 1'b0));
    send_peak(make_peak(32'h7FFF_FFFE, 32'hFFFF_FFFF, 1'b1));
    settle_idle();
  endtask

  // Short random spectra across several register settings
  task automatic test_random_spectra();
    logic [DATA_W-1:0] base;
    logic [DATA_W-1:0] floor_val;
    int                budget;
    int                len;
    for (int phase = 0; phase < 6; phase++) begin
      base = pick_base();
      case ($urandom_range(0, 4))
        0:       floor_val = '0;
        1:       floor_val = base;
        2:       floor_val = 32'hFFFF_FFFF;
        3:       floor_val = $urandom;
        default: floor_val = $urandom_range(0, base);
      endcase
      set_config(base, floor_val);
      budget = 30;
      while (budget > 0) begin
        len = $urandom_range(1, 12);
        if (len > budget) len = budget;
        send_spectrum(len, spread_t'($urandom_range(0, 5)));
        budget -= len;
      end
      settle_idle();
    end
  endtask

  // Overfill the store: evictions, dropped weak peaks and ties at the bottom
  task automatic test_full_store();
    set_config($urandom_range(1000, 1000000), '0);
    send_spectrum(70, SPREAD_CROWDED);
    send_spectrum(90, SPREAD_NARROW);
    settle_idle();
    set_config(32'hFFFF_FFFF, $urandom_range(0, 32'h7FFF_FFFF));
    send_spectrum(66, SPREAD_FULL);
    settle_idle();
  endtask

  initial begin
    reset_block();
    test_reset_levels();
    test_ties();
    test_thresholds();
    test_random_spectra();
    test_full_store();
    settle_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d peaks in %0d spectra over several base and threshold settings,",
             peaks_sent, spectra_sent);
    $display("checked %0d normalized peaks, %0d mismatches.", peaks_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
